/* hw/rtl/erez_pkg.sv */
package erez_pkg;

   localparam int DEN_BITS = 12;
   localparam logic [11:0] FIELD_MASK = 12'((1 << DEN_BITS) - 1);
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [3:0] {
      EASE_LINEAR,
      EASE_QUAD_IN,
      EASE_QUAD_OUT,
      EASE_QUAD_INOUT,
      EASE_CUBIC_IN,
      EASE_CUBIC_OUT,
      EASE_CUBIC_INOUT,
      EASE_QUART_IN,
      EASE_QUART_OUT,
      EASE_QUART_INOUT,
      EASE_QUINT_IN,
      EASE_QUINT_OUT,
      EASE_QUINT_INOUT,
      EASE_BOUNCE_IN,
      EASE_BOUNCE_OUT,
      EASE_BOUNCE_INOUT
   } ease_type;

   typedef struct packed {
      logic [3:0]  easing;
      logic [11:0] numerator;
      logic [11:0] denominator;
   } req_type;

   typedef struct packed {
      logic [59:0] eased_numerator;
      logic [59:0] eased_denominator;
      logic        error;
   } rsp_type;

   // One classified item: result = sub ? (Q*ofs - v) : (v + add*Q*ofs), den = Q << rd_sh,
   // where v is P << sh for a power curve and c1*P + c2*Q for a bounce.
   typedef struct packed {
      logic        err;
      logic        bounce;
      logic [2:0]  pw;
      logic [2:0]  sh;
      logic [8:0]  c1;
      logic [5:0]  c2;
      logic        sub;
      logic        add;
      logic        ofs64;
      logic [2:0]  rd_sh;
      logic [16:0] base;
      logic [11:0] den;
   } cmd_type;

endpackage

/* hw/rtl/exact_rational_easing.sv */
// Path: a request enters the queue, then the c1, c2, c3, c4 and output pipeline registers.
// Throughput: one item per cycle unless the output stalls; a four-entry queue separates the
// classifier from the multiplier pipeline, which back-pressure stalls as a whole.
// Reset: synchronous; empties the queue and clears every pipeline valid, so no result is
// offered in the cycle after reset.
module exact_rational_easing
   import erez_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type cmd_front, cmd_head;
   logic    q_not_empty, q_pop;

   erez_front u_front (
      .req_data (req_data),
      .cmd      (cmd_front)
   );

   erez_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data (cmd_front),
      .not_full  (req_ready),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (cmd_head)
   );

   erez_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_not_empty),
      .cmd       (cmd_head),
      .cmd_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* hw/rtl/erez_front.sv */
module erez_front
   import erez_pkg::*;
(
   input  req_type req_data,
   output cmd_type cmd
);

   logic [11:0] n, d, dmn;
   logic        half;
   logic [12:0] n2;
   logic [11:0] x;
   logic [15:0] e, d4, d8, d10, d6, d9;
   logic [16:0] x22, d21;
   logic [1:0]  kind;
   logic [2:0]  p;

   always_comb begin
      n    = req_data.numerator & FIELD_MASK;
      d    = req_data.denominator & FIELD_MASK;
      dmn  = d - n;
      n2   = {n, 1'b0};
      half = n2 < {1'b0, d};

      cmd        = '0;
      cmd.den    = d;
      cmd.err    = n > d;
      kind       = 2'd0;
      p          = 3'd1;
      x          = n;

      case (ease_type'(req_data.easing))
         EASE_LINEAR:       begin p = 3'd1; kind = 2'd0; end
         EASE_QUAD_IN:      begin p = 3'd2; kind = 2'd0; end
         EASE_QUAD_OUT:     begin p = 3'd2; kind = 2'd1; end
         EASE_QUAD_INOUT:   begin p = 3'd2; kind = 2'd2; end
         EASE_CUBIC_IN:     begin p = 3'd3; kind = 2'd0; end
         EASE_CUBIC_OUT:    begin p = 3'd3; kind = 2'd1; end
         EASE_CUBIC_INOUT:  begin p = 3'd3; kind = 2'd2; end
         EASE_QUART_IN:     begin p = 3'd4; kind = 2'd0; end
         EASE_QUART_OUT:    begin p = 3'd4; kind = 2'd1; end
         EASE_QUART_INOUT:  begin p = 3'd4; kind = 2'd2; end
         EASE_QUINT_IN:     begin p = 3'd5; kind = 2'd0; end
         EASE_QUINT_OUT:    begin p = 3'd5; kind = 2'd1; end
         EASE_QUINT_INOUT:  begin p = 3'd5; kind = 2'd2; end
         EASE_BOUNCE_IN:    begin p = 3'd2; kind = 2'd3; x = dmn; end
         EASE_BOUNCE_OUT:   begin p = 3'd2; kind = 2'd3; x = n; end
         EASE_BOUNCE_INOUT: begin
            p = 3'd2;
            kind = 2'd3;
            x = half ? 12'({1'b0, d} - n2) : 12'(n2 - {1'b0, d});
         end
         default:           begin p = 3'd1; kind = 2'd0; end
      endcase

      e   = 16'(x) * 16'd11;
      d4  = 16'(d) << 2;
      d8  = 16'(d) << 3;
      d10 = 16'(d) * 16'd10;
      d6  = 16'(d) * 16'd6;
      d9  = 16'(d) * 16'd9;
      x22 = 17'(x) * 17'd22;
      d21 = 17'(d) * 17'd21;

      cmd.pw = p;
      case (kind)
         2'd0: begin
            cmd.base = 17'(n);
         end
         2'd1: begin
            cmd.base = 17'(dmn);
            cmd.sub  = 1'b1;
         end
         2'd2: begin
            cmd.base = half ? 17'(n) : 17'(dmn);
            cmd.sub  = !half;
            cmd.sh   = p - 3'd1;
         end
         default: begin
            cmd.bounce = 1'b1;
            cmd.ofs64  = 1'b1;
            if (e < d4) begin
               cmd.base = 17'(x);
               cmd.c1   = 9'd484;
               cmd.c2   = 6'd0;
            end else if (e < d8) begin
               cmd.base = 17'((e >= d6) ? e - d6 : d6 - e);
               cmd.c1   = 9'd4;
               cmd.c2   = 6'd48;
            end else if (e < d10) begin
               cmd.base = 17'((e >= d9) ? e - d9 : d9 - e);
               cmd.c1   = 9'd4;
               cmd.c2   = 6'd60;
            end else begin
               cmd.base = (x22 >= d21) ? x22 - d21 : d21 - x22;
               cmd.c1   = 9'd1;
               cmd.c2   = 6'd63;
            end
            case (ease_type'(req_data.easing))
               EASE_BOUNCE_IN: begin
                  cmd.sub   = 1'b1;
                  cmd.rd_sh = 3'd6;
               end
               EASE_BOUNCE_OUT: begin
                  cmd.rd_sh = 3'd6;
               end
               default: begin
                  cmd.sub   = half;
                  cmd.add   = !half;
                  cmd.rd_sh = 3'd7;
               end
            endcase
         end
      endcase
   end

endmodule

/* hw/rtl/erez_queue.sv */
module erez_queue
   import erez_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    not_full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type head
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   cmd_type         mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]     cnt_ff, cnt_in;
   logic            do_push, do_pop;

   always_comb begin
      not_full  = cnt_ff != (PW+1)'(QUEUE_DEPTH);
      not_empty = cnt_ff != '0;
      do_push   = push && not_full;
      do_pop    = pop && not_empty;
      wr_in     = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in     = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in    = cnt_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);
      head      = mem_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/erez_back.sv */
module erez_back
   import erez_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    en;
   logic    v1_ff, v2_ff, v3_ff, v4_ff, vo_ff;
   cmd_type c1_ff, c2_ff, c3_ff, c4_ff;
   logic [33:0] b2_ff;
   logic [23:0] q2_ff;
   logic [35:0] b3_ff, q3_ff;
   logic [47:0] b4_ff, q4_ff;
   logic [33:0] b2k_ff;
   logic [23:0] q2k_ff;
   logic [59:0] p_ff, q_ff, p_in, q_in;
   logic [59:0] qv_ff, val_ff, val_in;
   logic [59:0] b5, q5, qoff, rn, rd;
   rsp_type     out_ff, out_in;

   assign en        = !vo_ff || rsp_ready;
   assign cmd_pop   = en && cmd_valid;
   assign rsp_valid = vo_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      b5 = 60'(b4_ff) * 60'(c2_ff.base[11:0]);
      q5 = 60'(q4_ff) * 60'(c2_ff.den);
      case (c2_ff.pw)
         3'd1:    begin p_in = 60'(c2_ff.base); q_in = 60'(c2_ff.den); end
         3'd2:    begin p_in = 60'(b2k_ff);     q_in = 60'(q2k_ff);    end
         3'd3:    begin p_in = 60'(b3_ff);      q_in = 60'(q3_ff);     end
         3'd4:    begin p_in = 60'(b4_ff);      q_in = 60'(q4_ff);     end
         default: begin p_in = b5;              q_in = q5;             end
      endcase

      if (c3_ff.bounce) begin
         val_in = 60'(p_ff[33:0] * 43'(c3_ff.c1)) + 60'(q_ff[23:0] * 30'(c3_ff.c2));
      end else begin
         val_in = p_ff << c3_ff.sh;
      end

      qoff = c4_ff.ofs64 ? (qv_ff << 6) : qv_ff;
      rn   = c4_ff.sub ? qoff - val_ff : (c4_ff.add ? val_ff + qoff : val_ff);
      rd   = qv_ff << c4_ff.rd_sh;
      out_in.error             = c4_ff.err;
      out_in.eased_numerator   = c4_ff.err ? '0 : rn;
      out_in.eased_denominator = c4_ff.err ? '0 : rd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= cmd_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         vo_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff  <= cmd;
         b2_ff  <= 34'(cmd.base) * 34'(cmd.base);
         q2_ff  <= 24'(cmd.den) * 24'(cmd.den);

         c2_ff  <= c1_ff;
         b3_ff  <= 36'(b2_ff[23:0]) * 36'(c1_ff.base[11:0]);
         q3_ff  <= 36'(q2_ff) * 36'(c1_ff.den);
         b4_ff  <= 48'(b2_ff[23:0]) * 48'(b2_ff[23:0]);
         q4_ff  <= 48'(q2_ff) * 48'(q2_ff);
         b2k_ff <= b2_ff;
         q2k_ff <= q2_ff;

         c3_ff  <= c2_ff;
         p_ff   <= p_in;
         q_ff   <= q_in;

         c4_ff  <= c3_ff;
         val_ff <= val_in;
         qv_ff  <= q_ff;

         out_ff <= out_in;
      end
   end

endmodule

/* hw/rtl/erez_checker.sv */
module erez_checker
   import erez_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error |->
         rsp_data.eased_numerator == '0 && rsp_data.eased_denominator == '0)
      else $error("error result carries a nonzero fraction");

   a_le_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.error |->
         rsp_data.eased_numerator <= rsp_data.eased_denominator)
      else $error("eased progress exceeds one");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

endmodule

bind exact_rational_easing erez_checker u_erez_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
